[rtl/rtpfr_pkg.sv]
// ----------------------------------------------------------------------------
// rtpfr_pkg
// Shared widths, constants and controller/datapath handshake types for the
// RTP frame rate observer.
// ----------------------------------------------------------------------------
package rtpfr_pkg;

   // field widths
   localparam int WORD_W = 32;
   localparam int RATE_W = 31;

   // binary gcd common power of two, at most WORD_W-1
   localparam int SHIFT_W = $clog2(WORD_W);

   // divider step counter
   localparam int CNT_W = $clog2(WORD_W);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(WORD_W - 1);

   // clock rate after reset
   localparam logic [RATE_W-1:0] CLOCK_RATE_RESET = RATE_W'(90000);

   // input function codes
   localparam logic FUNC_OBSERVE = 1'b0;
   localparam logic FUNC_DISCONT = 1'b1;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic gcd_step;
      logic div_start;
      logic div_step;
      logic commit;
      logic respond;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic need_rate;
      logic gcd_done;
   } sts_type;

endpackage

[rtl/rtpfr_if.sv]
// ----------------------------------------------------------------------------
// rtpfr channel interfaces
// Valid/ready channels for packet words, result words and the clock rate
// register write.
// ----------------------------------------------------------------------------

// packet header word
interface rtpfr_req_if import rtpfr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              func;
   logic [WORD_W-1:0] ssrc;
   logic              marker;
   logic [WORD_W-1:0] timestamp;

   modport source (output valid, func, ssrc, marker, timestamp, input ready);
   modport sink   (input valid, func, ssrc, marker, timestamp, output ready);
endinterface

// result word
interface rtpfr_rsp_if import rtpfr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              status;
   logic              rate_valid;
   logic [RATE_W-1:0] rate_numerator;
   logic [RATE_W-1:0] rate_denominator;

   modport source (output valid, status, rate_valid, rate_numerator, rate_denominator,
                   input ready);
   modport sink   (input valid, status, rate_valid, rate_numerator, rate_denominator,
                   output ready);
endinterface

// clock rate register write
interface rtpfr_csr_if import rtpfr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [RATE_W-1:0] clock_rate;

   modport source (output valid, clock_rate, input ready);
   modport sink   (input valid, clock_rate, output ready);
endinterface

[rtl/rtpfr_datapath.sv]
// ----------------------------------------------------------------------------
// rtpfr_datapath
// Source tracking state, binary gcd unit, two restoring dividers and the
// result word register.
// ----------------------------------------------------------------------------
module rtpfr_datapath import rtpfr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output sts_type           sts,
   input  logic              req_func,
   input  logic [WORD_W-1:0] req_ssrc,
   input  logic              req_marker,
   input  logic [WORD_W-1:0] req_timestamp,
   input  logic              csr_we,
   input  logic [RATE_W-1:0] csr_clock_rate,
   output logic              rsp_status,
   output logic              rsp_rate_valid,
   output logic [RATE_W-1:0] rsp_rate_numerator,
   output logic [RATE_W-1:0] rsp_rate_denominator
);

   // control state
   logic               src_valid_ff, src_valid_in;
   logic               unit_valid_ff, unit_valid_in;
   logic               rate_valid_ff, rate_valid_in;
   logic               err_ff, err_in;
   logic [RATE_W-1:0]  clock_rate_ff, clock_rate_in;

   // payload state
   logic [WORD_W-1:0]  cur_src_ff, cur_src_in;
   logic [WORD_W-1:0]  unit_time_ff, unit_time_in;
   logic [RATE_W-1:0]  rate_num_ff, rate_num_in;
   logic [RATE_W-1:0]  rate_den_ff, rate_den_in;
   logic [WORD_W-1:0]  delta_ff, delta_in;
   logic [WORD_W-1:0]  a_ff, a_in;
   logic [WORD_W-1:0]  b_ff, b_in;
   logic [SHIFT_W-1:0] k_ff, k_in;
   logic [WORD_W-1:0]  divisor_ff, divisor_in;
   logic [WORD_W-1:0]  rem0_ff, rem0_in;
   logic [WORD_W-1:0]  quo0_ff, quo0_in;
   logic [WORD_W-1:0]  rem1_ff, rem1_in;
   logic [WORD_W-1:0]  quo1_ff, quo1_in;
   logic               out_status_ff, out_status_in;
   logic               out_valid_ff, out_valid_in;
   logic [RATE_W-1:0]  out_num_ff, out_num_in;
   logic [RATE_W-1:0]  out_den_ff, out_den_in;

   // intermediate terms
   logic               new_src;
   logic [WORD_W-1:0]  delta;
   logic               a_ge_b;
   logic [WORD_W-1:0]  a_minus_b;
   logic [WORD_W-1:0]  b_minus_a;
   logic [WORD_W:0]    trial0;
   logic [WORD_W:0]    trial1;
   logic               ge0;
   logic               ge1;

   // next state
   always_comb begin
      src_valid_in  = src_valid_ff;
      unit_valid_in = unit_valid_ff;
      rate_valid_in = rate_valid_ff;
      err_in        = err_ff;
      clock_rate_in = clock_rate_ff;
      cur_src_in    = cur_src_ff;
      unit_time_in  = unit_time_ff;
      rate_num_in   = rate_num_ff;
      rate_den_in   = rate_den_ff;
      delta_in      = delta_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      k_in          = k_ff;
      divisor_in    = divisor_ff;
      rem0_in       = rem0_ff;
      quo0_in       = quo0_ff;
      rem1_in       = rem1_ff;
      quo1_in       = quo1_ff;
      out_status_in = out_status_ff;
      out_valid_in  = out_valid_ff;
      out_num_in    = out_num_ff;
      out_den_in    = out_den_ff;

      new_src   = !src_valid_ff || (cur_src_ff != req_ssrc);
      delta     = req_timestamp - unit_time_ff;
      a_ge_b    = (a_ff >= b_ff);
      a_minus_b = a_ff - b_ff;
      b_minus_a = b_ff - a_ff;
      trial0    = {rem0_ff, quo0_ff[WORD_W-1]};
      trial1    = {rem1_ff, quo1_ff[WORD_W-1]};
      ge0       = (trial0 >= {1'b0, divisor_ff});
      ge1       = (trial1 >= {1'b0, divisor_ff});

      sts.need_rate = (req_func == FUNC_OBSERVE) && req_marker && !new_src &&
                      unit_valid_ff && (delta != '0);
      sts.gcd_done  = (a_ff == '0) || (b_ff == '0);

      // register write
      if (csr_we) begin
         clock_rate_in = csr_clock_rate;
      end

      // take a packet word, update source tracking, seed the gcd
      if (cmd.load) begin
         err_in   = 1'b0;
         a_in     = {1'b0, clock_rate_ff};
         b_in     = delta;
         k_in     = '0;
         delta_in = delta;
         if (req_func == FUNC_DISCONT) begin
            src_valid_in  = 1'b0;
            unit_valid_in = 1'b0;
            rate_valid_in = 1'b0;
         end else begin
            if (new_src) begin
               src_valid_in  = 1'b1;
               cur_src_in    = req_ssrc;
               unit_valid_in = 1'b0;
               rate_valid_in = 1'b0;
            end
            if (req_marker) begin
               unit_valid_in = 1'b1;
               unit_time_in  = req_timestamp;
            end
         end
      end

      // binary gcd, one step a cycle
      if (cmd.gcd_step) begin
         case ({a_ff[0], b_ff[0]})
            2'b00: begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
               k_in = k_ff + SHIFT_W'(1);
            end
            2'b01: begin
               a_in = a_ff >> 1;
            end
            2'b10: begin
               b_in = b_ff >> 1;
            end
            default: begin
               if (a_ge_b) begin
                  a_in = a_minus_b >> 1;
               end else begin
                  b_in = b_minus_a >> 1;
               end
            end
         endcase
      end

      // divide both operands by the odd part of the gcd, power of two shifted out
      if (cmd.div_start) begin
         divisor_in = a_ff | b_ff;
         rem0_in    = '0;
         rem1_in    = '0;
         quo0_in    = {1'b0, clock_rate_ff} >> k_ff;
         quo1_in    = delta_ff >> k_ff;
      end

      // restoring divide step on both dividers
      if (cmd.div_step) begin
         rem0_in = ge0 ? WORD_W'(trial0 - {1'b0, divisor_ff}) : trial0[WORD_W-1:0];
         rem1_in = ge1 ? WORD_W'(trial1 - {1'b0, divisor_ff}) : trial1[WORD_W-1:0];
         quo0_in = {quo0_ff[WORD_W-2:0], ge0};
         quo1_in = {quo1_ff[WORD_W-2:0], ge1};
      end

      // keep the new rate unless the denominator overflows
      if (cmd.commit) begin
         if (quo1_ff[WORD_W-1]) begin
            err_in = 1'b1;
         end else begin
            rate_valid_in = 1'b1;
            rate_num_in   = quo0_ff[RATE_W-1:0];
            rate_den_in   = quo1_ff[RATE_W-1:0];
         end
      end

      // result word
      if (cmd.respond) begin
         out_status_in = err_ff;
         out_valid_in  = rate_valid_ff;
         out_num_in    = rate_valid_ff ? rate_num_ff : '0;
         out_den_in    = rate_valid_ff ? rate_den_ff : '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_valid_ff  <= 1'b0;
         unit_valid_ff <= 1'b0;
         rate_valid_ff <= 1'b0;
         err_ff        <= 1'b0;
         clock_rate_ff <= CLOCK_RATE_RESET;
      end else begin
         src_valid_ff  <= src_valid_in;
         unit_valid_ff <= unit_valid_in;
         rate_valid_ff <= rate_valid_in;
         err_ff        <= err_in;
         clock_rate_ff <= clock_rate_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_src_ff    <= cur_src_in;
      unit_time_ff  <= unit_time_in;
      rate_num_ff   <= rate_num_in;
      rate_den_ff   <= rate_den_in;
      delta_ff      <= delta_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      k_ff          <= k_in;
      divisor_ff    <= divisor_in;
      rem0_ff       <= rem0_in;
      quo0_ff       <= quo0_in;
      rem1_ff       <= rem1_in;
      quo1_ff       <= quo1_in;
      out_status_ff <= out_status_in;
      out_valid_ff  <= out_valid_in;
      out_num_ff    <= out_num_in;
      out_den_ff    <= out_den_in;
   end

   assign rsp_status           = out_status_ff;
   assign rsp_rate_valid       = out_valid_ff;
   assign rsp_rate_numerator   = out_num_ff;
   assign rsp_rate_denominator = out_den_ff;

endmodule

[rtl/rtpfr_ctrl.sv]
// ----------------------------------------------------------------------------
// rtpfr_ctrl
// Sequencer: accepts a packet word, runs gcd and divide when a rate is due,
// then presents the result word.
// ----------------------------------------------------------------------------
module rtpfr_ctrl import rtpfr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_GCD    = 3'd1;
   localparam logic [2:0] ST_DIV    = 3'd2;
   localparam logic [2:0] ST_COMMIT = 3'd3;
   localparam logic [2:0] ST_RESP   = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   // sequencing
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;

      // result word taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               state_in = sts.need_rate ? ST_GCD : ST_RESP;
            end
         end
         ST_GCD: begin
            if (sts.gcd_done) begin
               cmd.div_start = 1'b1;
               cnt_in        = '0;
               state_in      = ST_DIV;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            cmd.respond  = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/rtp_video_frame_rate_observer_unit.sv]
// ----------------------------------------------------------------------------
// rtp_video_frame_rate_observer_unit
// Sequence: with no rate formed, an accepted word goes straight to the result
// word; with a rate, binary gcd steps, then divide steps, a commit, the result.
// Throughput: one word at a time; the next is taken once the result is gone,
// set by the shared gcd unit and the 32 step restoring dividers.
// Reset: synchronous; clears the source, unit and rate valid flags and sets clock_rate to 90000.
// ----------------------------------------------------------------------------
module rtp_video_frame_rate_observer_unit import rtpfr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   rtpfr_req_if.sink    req_chan,
   rtpfr_rsp_if.source  rsp_chan,
   rtpfr_csr_if.sink    csr_chan
);

   cmd_type cmd;
   sts_type sts;

   // register port always ready
   assign csr_chan.ready = 1'b1;

   // sequencer
   rtpfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath
   rtpfr_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_func             (req_chan.func),
      .req_ssrc             (req_chan.ssrc),
      .req_marker           (req_chan.marker),
      .req_timestamp        (req_chan.timestamp),
      .csr_we               (csr_chan.valid && csr_chan.ready),
      .csr_clock_rate       (csr_chan.clock_rate),
      .rsp_status           (rsp_chan.status),
      .rsp_rate_valid       (rsp_chan.rate_valid),
      .rsp_rate_numerator   (rsp_chan.rate_numerator),
      .rsp_rate_denominator (rsp_chan.rate_denominator)
   );

endmodule
